[rtl/dcpb_pkg.sv]
`default_nettype none
package dcpb_pkg;

  localparam int unsigned ColorW   = 16;
  localparam int unsigned RgbW     = 15;
  localparam int unsigned ChanW    = 5;
  localparam int unsigned IndexW   = 4;
  localparam int unsigned CoeffW   = 5;
  localparam int unsigned WeightW  = 9;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;
  localparam int unsigned NumChan  = 3;

  localparam logic [CfgIdxW-1:0] CFG_TARGET_A  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_COEFF_A   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TARGET_B  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_COEFF_B   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MIX_W     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_DEFAULT_C = 3'd5;

  typedef enum logic [1:0] {
    K_DROP  = 2'd0,
    K_COPY  = 2'd1,
    K_BLEND = 2'd2
  } kind_e;

  typedef struct packed {
    logic capture;
    logic lerp;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic blend;
  } sts_t;

  function automatic logic [ChanW-1:0] clamp5(input logic signed [15:0] v);
    logic [ChanW-1:0] r;
    if (v < 16'sd0) begin
      r = '0;
    end else if (v > 16'sd31) begin
      r = 5'd31;
    end else begin
      r = v[ChanW-1:0];
    end
    return r;
  endfunction

  // c + floor((t - c) * 2*coeff / 32), saturated to a channel.
  function automatic logic [ChanW-1:0] lerp5(input logic [ChanW-1:0] c,
                                             input logic [ChanW-1:0] t,
                                             input logic [CoeffW-1:0] coeff);
    logic signed [5:0]  diff;
    logic signed [6:0]  cf;
    logic signed [12:0] prod;
    logic signed [12:0] sum;
    diff = $signed({1'b0, t}) - $signed({1'b0, c});
    cf   = $signed({1'b0, coeff, 1'b0});
    prod = 13'(diff) * 13'(cf);
    sum  = 13'($signed({1'b0, c})) + (prod >>> 5);
    return clamp5(16'(sum));
  endfunction

  // v2 + floor((v1 - v2) * w / 256), saturated to a channel.
  function automatic logic [ChanW-1:0] mix5(input logic [ChanW-1:0] v1,
                                            input logic [ChanW-1:0] v2,
                                            input logic [WeightW-1:0] w);
    logic signed [5:0]  diff;
    logic signed [9:0]  ws;
    logic signed [15:0] prod;
    logic signed [15:0] sum;
    diff = $signed({1'b0, v1}) - $signed({1'b0, v2});
    ws   = $signed({1'b0, w});
    prod = 16'(diff) * 16'(ws);
    sum  = 16'($signed({1'b0, v2})) + (prod >>> 8);
    return clamp5(sum);
  endfunction

endpackage
`default_nettype wire

[rtl/dcpb_if.sv]
`default_nettype none
interface dcpb_in_if;
  logic                           valid;
  logic                           ready;
  logic [dcpb_pkg::ColorW-1:0]    color_in;
  logic [dcpb_pkg::IndexW-1:0]    entry_index;
  logic                           selected;

  modport source (output valid, output color_in, output entry_index, output selected,
                  input ready);
  modport sink (input valid, input color_in, input entry_index, input selected,
                output ready);
endinterface

interface dcpb_out_if;
  logic                        valid;
  logic                        ready;
  logic [dcpb_pkg::ColorW-1:0] color_out;
  logic                        write_enable;

  modport source (output valid, output color_out, output write_enable, input ready);
  modport sink (input valid, input color_out, input write_enable, output ready);
endinterface
`default_nettype wire

[rtl/dcpb_ctrl.sv]
`default_nettype none
module dcpb_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire dcpb_pkg::sts_t sts_i,
  output dcpb_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WORK = 3'b010,
    S_MIX  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  // The output register is free when empty or when its beat leaves now.
  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.capture = in_valid_i && (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_WORK;
        end
      end
      S_WORK: begin
        if (sts_i.blend) begin
          cmd_o.lerp = 1'b1;
          state_d    = S_MIX;
        end else if (slot_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_MIX: begin
        if (slot_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

[rtl/dcpb_datapath.sv]
`default_nettype none
module dcpb_datapath #(
  parameter int unsigned PALETTE_ENTRIES = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [dcpb_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [dcpb_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wire logic [dcpb_pkg::ColorW-1:0]       color_in_i,
  input  wire logic [dcpb_pkg::IndexW-1:0]       entry_index_i,
  input  wire logic                              selected_i,
  input  wire dcpb_pkg::cmd_t                    cmd_i,
  output dcpb_pkg::sts_t                         sts_o,
  output logic [dcpb_pkg::ColorW-1:0]            color_out_o,
  output logic                                   write_enable_o
);

  localparam int unsigned CW = dcpb_pkg::ChanW;
  localparam logic [8:0] EntriesLim = 9'(PALETTE_ENTRIES);

  logic [dcpb_pkg::RgbW-1:0]    target_a_q, target_b_q, default_q;
  logic [dcpb_pkg::CoeffW-1:0]  coeff_a_q, coeff_b_q;
  logic [dcpb_pkg::WeightW-1:0] mix_w_q;

  logic [dcpb_pkg::RgbW-1:0]    alt_color_q;
  logic                         alt_valid_q;

  logic [dcpb_pkg::ColorW-1:0]  color_q;
  dcpb_pkg::kind_e              kind_q, kind_d;

  logic [dcpb_pkg::RgbW-1:0]    v1_q, v2_q, v1_d, v2_d;
  logic [dcpb_pkg::RgbW-1:0]    ta, tb, mixed;
  logic [dcpb_pkg::ColorW-1:0]  color_out_q, color_out_d;
  logic                         we_q, we_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_a_q <= '0;
      coeff_a_q  <= '0;
      target_b_q <= '0;
      coeff_b_q  <= '0;
      mix_w_q    <= '0;
      default_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dcpb_pkg::CFG_TARGET_A:  target_a_q <= cfg_data_i;
        dcpb_pkg::CFG_COEFF_A:   coeff_a_q  <= cfg_data_i[dcpb_pkg::CoeffW-1:0];
        dcpb_pkg::CFG_TARGET_B:  target_b_q <= cfg_data_i;
        dcpb_pkg::CFG_COEFF_B:   coeff_b_q  <= cfg_data_i[dcpb_pkg::CoeffW-1:0];
        dcpb_pkg::CFG_MIX_W:     mix_w_q    <= cfg_data_i[dcpb_pkg::WeightW-1:0];
        dcpb_pkg::CFG_DEFAULT_C: default_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (!selected_i || ({5'd0, entry_index_i} >= EntriesLim)) begin
      kind_d = dcpb_pkg::K_DROP;
    end else if (entry_index_i == '0) begin
      kind_d = dcpb_pkg::K_COPY;
    end else begin
      kind_d = dcpb_pkg::K_BLEND;
    end
  end

  // The alternate color is latched at capture; a blended entry is never
  // entry 0, so its own capture leaves the alternate color untouched.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alt_color_q <= '0;
      alt_valid_q <= 1'b0;
    end else if (cmd_i.capture && (kind_d == dcpb_pkg::K_COPY)) begin
      if (color_in_i[dcpb_pkg::ColorW-1]) begin
        alt_color_q <= color_in_i[dcpb_pkg::RgbW-1:0];
        alt_valid_q <= 1'b1;
      end else begin
        alt_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      color_q <= color_in_i;
      kind_q  <= kind_d;
    end
  end

  assign sts_o.blend = (kind_q == dcpb_pkg::K_BLEND);

  always_comb begin
    if (color_q[dcpb_pkg::ColorW-1]) begin
      ta = alt_valid_q ? alt_color_q : default_q;
      tb = ta;
    end else begin
      ta = target_a_q;
      tb = target_b_q;
    end
    for (int k = 0; k < dcpb_pkg::NumChan; k++) begin
      v1_d[CW*k +: CW] = dcpb_pkg::lerp5(color_q[CW*k +: CW], ta[CW*k +: CW], coeff_a_q);
      v2_d[CW*k +: CW] = dcpb_pkg::lerp5(color_q[CW*k +: CW], tb[CW*k +: CW], coeff_b_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lerp) begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  always_comb begin
    for (int k = 0; k < dcpb_pkg::NumChan; k++) begin
      mixed[CW*k +: CW] = dcpb_pkg::mix5(v1_q[CW*k +: CW], v2_q[CW*k +: CW], mix_w_q);
    end
    case (kind_q)
      dcpb_pkg::K_COPY: begin
        color_out_d = color_q;
        we_d        = 1'b1;
      end
      dcpb_pkg::K_BLEND: begin
        color_out_d = {1'b0, mixed};
        we_d        = 1'b1;
      end
      default: begin
        color_out_d = '0;
        we_d        = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      color_out_q <= color_out_d;
      we_q        <= we_d;
    end
  end

  assign color_out_o    = color_out_q;
  assign write_enable_o = we_q;

endmodule
`default_nettype wire

[rtl/dual_color_palette_blend.sv]
`default_nettype none
// Channel  Dir  Beat fields
// in_i     in   color_in[16], entry_index[4], selected[1]
// out_o    out  color_out[16], write_enable[1]
// cfg      in   cfg_we_i, cfg_index_i[3], cfg_data_i[15] (write only)
//
// A blended entry passes through capture, the lerp stage and the mix stage to
// its result in the output register. Entry 0 and dropped entries skip the lerp
// stage. One entry is in flight at a time; the controller sequences it.
// Reset clears the configuration registers, the alternate color and control.
// A stalled output holds its beat; the next input beat is still taken, and the
// controller waits in its final state until the output register frees up.
module dual_color_palette_blend #(
  parameter int unsigned PALETTE_ENTRIES = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [dcpb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [dcpb_pkg::CfgDataW-1:0] cfg_data_i,
  dcpb_in_if.sink                            in_i,
  dcpb_out_if.source                         out_o
);

  dcpb_pkg::cmd_t cmd;
  dcpb_pkg::sts_t sts;

  dcpb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dcpb_datapath #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .color_in_i     (in_i.color_in),
    .entry_index_i  (in_i.entry_index),
    .selected_i     (in_i.selected),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .color_out_o    (out_o.color_out),
    .write_enable_o (out_o.write_enable)
  );

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken while an entry is in flight");

  a_result_follows_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(!in_i.ready))
    else $error("result appeared without an entry in flight");

  a_drop_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.write_enable) |-> (out_o.color_out == '0))
    else $error("unwritten entry carries a nonzero color");

  a_load_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (!out_o.valid || out_o.ready))
    else $error("output register overwritten while its beat waits");

endmodule
`default_nettype wire

[tb/dcpb_blend_checker.sv]
module dcpb_blend_checker #(
  parameter int unsigned PALETTE_ENTRIES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dcpb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dcpb_pkg::CfgDataW-1:0] cfg_data_i,
  dcpb_in_if                            in_mon,
  dcpb_out_if                           out_mon,
  output int unsigned                   mismatches_o,
  output int unsigned                   pending_o
);

  typedef struct packed {
    logic [dcpb_pkg::ColorW-1:0] color;
    logic                        we;
  } palette_write_t;

  // Shadow of the configuration registers, kept from the write port.
  logic [dcpb_pkg::RgbW-1:0]    target_a;
  logic [dcpb_pkg::CoeffW-1:0]  coeff_a;
  logic [dcpb_pkg::RgbW-1:0]    target_b;
  logic [dcpb_pkg::CoeffW-1:0]  coeff_b;
  logic [dcpb_pkg::WeightW-1:0] mix_weight;
  logic [dcpb_pkg::RgbW-1:0]    default_color;

  logic [dcpb_pkg::RgbW-1:0]    alt_color;
  logic                         alt_valid;

  palette_write_t expected_writes[$];
  palette_write_t oldest;

  function automatic logic [4:0] sat_chan(input int v);
    if (v < 0) return 5'd0;
    if (v > 31) return 5'd31;
    return v[4:0];
  endfunction

  // The arithmetic shift on a signed int gives the floor of the division.
  function automatic logic [4:0] lerp_chan(input logic [4:0] c, input logic [4:0] t,
                                           input logic [4:0] k);
    int d;
    d = (int'(t) - int'(c)) * (2 * int'(k));
    return sat_chan(int'(c) + (d >>> 5));
  endfunction

  function automatic logic [4:0] mix_chan(input logic [4:0] v1, input logic [4:0] v2,
                                          input logic [8:0] w);
    int d;
    d = (int'(v1) - int'(v2)) * int'(w);
    return sat_chan(int'(v2) + (d >>> 8));
  endfunction

  function automatic palette_write_t blend_entry(input logic [15:0] color,
                                                 input logic [3:0] idx, input logic sel);
    palette_write_t res;
    logic [14:0] ta;
    logic [14:0] tb;
    logic [4:0] v1;
    logic [4:0] v2;
    res = '0;
    if (!sel || idx >= PALETTE_ENTRIES) return res;
    res.we = 1'b1;
    if (idx == 4'd0) begin
      alt_valid = color[15];
      if (color[15]) alt_color = color[14:0];
      res.color = color;
      return res;
    end
    if (color[15]) begin
      ta = alt_valid ? alt_color : default_color;
      tb = ta;
    end else begin
      ta = target_a;
      tb = target_b;
    end
    for (int k = 0; k < 3; k++) begin
      v1 = lerp_chan(color[5*k +: 5], ta[5*k +: 5], coeff_a);
      v2 = lerp_chan(color[5*k +: 5], tb[5*k +: 5], coeff_b);
      res.color[5*k +: 5] = mix_chan(v1, v2, mix_weight);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_a      = '0;
      coeff_a       = '0;
      target_b      = '0;
      coeff_b       = '0;
      mix_weight    = '0;
      default_color = '0;
      alt_color     = '0;
      alt_valid     = 1'b0;
      expected_writes.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          dcpb_pkg::CFG_TARGET_A:  target_a = cfg_data_i[dcpb_pkg::RgbW-1:0];
          dcpb_pkg::CFG_COEFF_A:   coeff_a = cfg_data_i[dcpb_pkg::CoeffW-1:0];
          dcpb_pkg::CFG_TARGET_B:  target_b = cfg_data_i[dcpb_pkg::RgbW-1:0];
          dcpb_pkg::CFG_COEFF_B:   coeff_b = cfg_data_i[dcpb_pkg::CoeffW-1:0];
          dcpb_pkg::CFG_MIX_W:     mix_weight = cfg_data_i[dcpb_pkg::WeightW-1:0];
          dcpb_pkg::CFG_DEFAULT_C: default_color = cfg_data_i[dcpb_pkg::RgbW-1:0];
          default: ;
        endcase
      end
      // An output beat always belongs to an older input beat, so pop first.
      if (out_mon.valid && out_mon.ready) begin
        if (expected_writes.size() == 0) begin
          report_mismatch($sformatf("unexpected output beat color_out=%h write_enable=%b",
                                    out_mon.color_out, out_mon.write_enable));
        end else begin
          oldest = expected_writes.pop_front();
          if (out_mon.color_out !== oldest.color)
            report_mismatch($sformatf("color_out %h, expected %h",
                                      out_mon.color_out, oldest.color));
          if (out_mon.write_enable !== oldest.we)
            report_mismatch($sformatf("write_enable %b, expected %b",
                                      out_mon.write_enable, oldest.we));
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_writes.push_back(blend_entry(in_mon.color_in, in_mon.entry_index,
                                              in_mon.selected));
    end
    pending_o = expected_writes.size();
  end

endmodule

[tb/tb_dual_color_palette_blend.sv]
module tb_dual_color_palette_blend;

  localparam int unsigned EntryCount   = 16;
  localparam int unsigned HalfPeriod   = 4;
  localparam int unsigned ResetCycles  = 5;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned IdleLimit    = 1000;
  localparam int unsigned PhaseCount   = 8;
  localparam int unsigned PhaseItems   = 230;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [dcpb_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [dcpb_pkg::CfgDataW-1:0] cfg_data_i;

  int unsigned mismatches;
  int unsigned pending_writes;
  int unsigned idle_cycles;
  int unsigned ready_hold;
  logic        gapless;

  dcpb_in_if  in_if ();
  dcpb_out_if out_if ();

  always #(HalfPeriod) clk_i = ~clk_i;

  dual_color_palette_blend #(
    .PALETTE_ENTRIES(EntryCount)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  dcpb_blend_checker #(
    .PALETTE_ENTRIES(EntryCount)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .mismatches_o(mismatches),
    .pending_o   (pending_writes)
  );

  // Output back-pressure: mostly short stalls, a few long ones, and some
  // long stretches with ready held high.
  always @(negedge clk_i) begin
    int unsigned r;
    if (ready_hold != 0) begin
      ready_hold--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        out_if.ready <= 1'b1;
        ready_hold = $urandom_range(0, 6);
      end else if (r < 65) begin
        out_if.ready <= 1'b1;
        ready_hold = $urandom_range(20, 80);
      end else if (r < 95) begin
        out_if.ready <= 1'b0;
        ready_hold = $urandom_range(0, 3);
      end else begin
        out_if.ready <= 1'b0;
        ready_hold = $urandom_range(8, 40);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic int unsigned beat_gap();
    int unsigned r;
    if (gapless) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [15:0] random_color();
    case ($urandom_range(0, 15))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'hFFFF;
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  task automatic send_beat(input logic [15:0] color, input logic [3:0] idx, input logic sel);
    int unsigned gap;
    gap = beat_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_if.valid       <= 1'b1;
    in_if.color_in    <= color;
    in_if.entry_index <= idx;
    in_if.selected    <= sel;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Stop the stream and let the block go quiet before a register write.
  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_writes != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [dcpb_pkg::CfgIdxW-1:0] idx,
                           input logic [dcpb_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
  endtask

  task automatic load_blend_cfg(input logic [14:0] ta, input logic [14:0] ca,
                                input logic [14:0] tb, input logic [14:0] cb,
                                input logic [14:0] mw, input logic [14:0] dc);
    drain();
    write_reg(dcpb_pkg::CFG_TARGET_A, ta);
    write_reg(dcpb_pkg::CFG_COEFF_A, ca);
    write_reg(dcpb_pkg::CFG_TARGET_B, tb);
    write_reg(dcpb_pkg::CFG_COEFF_B, cb);
    write_reg(dcpb_pkg::CFG_MIX_W, mw);
    write_reg(dcpb_pkg::CFG_DEFAULT_C, dc);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // A whole palette most of the time; now and then it is cut short.
  task automatic send_palette(output int unsigned count);
    int unsigned len;
    logic        sel;
    logic [15:0] c;
    gapless = ($urandom_range(0, 4) == 0);
    sel = ($urandom_range(0, 4) != 0);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, EntryCount - 1) : EntryCount;
    for (int unsigned i = 0; i < len; i++) begin
      c = random_color();
      send_beat(c, 4'(i), sel);
    end
    count = len;
  endtask

  task automatic run_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        send_palette(len);
        sent += len;
      end else begin
        gapless = 1'b0;
        send_beat(random_color(), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_index_i       = '0;
    cfg_data_i        = '0;
    in_if.valid       = 1'b0;
    in_if.color_in    = '0;
    in_if.entry_index = '0;
    in_if.selected    = 1'b0;
    out_if.ready      = 1'b0;
    gapless           = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    load_blend_cfg(15'h7C00, 15'd8, 15'h001F, 15'd12, 15'd96, 15'h03E0);
    // Marked and plain entries before any entry 0 has been seen.
    send_beat(16'h8000, 4'd5, 1'b1);
    send_beat(16'h9C63, 4'd6, 1'b1);
    send_beat(16'h0000, 4'd2, 1'b1);
    send_beat(16'h7FFF, 4'd15, 1'b1);
    // Marked entry 0 latches an alternate target.
    send_beat(16'h83E0, 4'd0, 1'b1);
    send_beat(16'hFFFF, 4'd1, 1'b1);
    send_beat(16'hFFFF, 4'd7, 1'b0);
    // An unselected entry 0 must leave the latched color alone.
    send_beat(16'h8123, 4'd0, 1'b0);
    send_beat(16'h8000, 4'd3, 1'b1);
    // Plain entry 0 drops the alternate, so marked entries use the default.
    send_beat(16'h7FFF, 4'd0, 1'b1);
    send_beat(16'h9234, 4'd4, 1'b1);
    send_beat(16'hFFFF, 4'd0, 1'b1);
    send_beat(16'h8000, 4'd15, 1'b1);
    send_beat(16'h5555, 4'd8, 1'b1);
    send_beat(16'hAAAA, 4'd9, 1'b1);
    send_beat(16'h0000, 4'd0, 1'b1);
    send_beat(16'h0000, 4'd1, 1'b1);
    send_beat(16'hFFFF, 4'd14, 1'b0);

    for (int unsigned p = 0; p < PhaseCount; p++) begin
      case (p)
        0: load_blend_cfg(15'h0000, 15'd0, 15'h0000, 15'd0, 15'd0, 15'h0000);
        1: load_blend_cfg(15'h7FFF, 15'd16, 15'h7FFF, 15'd16, 15'd256, 15'h0000);
        2: load_blend_cfg(15'h0000, 15'd16, 15'h0000, 15'd16, 15'd0, 15'h7FFF);
        // Above the documented ranges: channels saturate.
        3: load_blend_cfg(15'($urandom), 15'd31, 15'($urandom), 15'd31, 15'd511,
                          15'($urandom));
        4: load_blend_cfg(15'($urandom), 15'd0, 15'($urandom), 15'd16, 15'd128,
                          15'($urandom));
        default: load_blend_cfg(15'($urandom), 15'($urandom_range(0, 16)), 15'($urandom),
                                15'($urandom_range(0, 16)), 15'($urandom_range(0, 256)),
                                15'($urandom));
      endcase
      run_phase(PhaseItems);
    end

    drain();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/dcpb_pkg.sv
rtl/dcpb_if.sv
rtl/dcpb_ctrl.sv
rtl/dcpb_datapath.sv
rtl/dual_color_palette_blend.sv
tb/dcpb_blend_checker.sv
tb/tb_dual_color_palette_blend.sv
